// File: rtl/core/thash_pkg.sv
// constants for the tiger hash engine: chaining init values, key schedule
// constants and the 512-bit seed block used to build the s-boxes
// no dependencies
package thash_pkg;

  localparam logic [63:0] INIT_A = 64'h0123456789ABCDEF;
  localparam logic [63:0] INIT_B = 64'hFEDCBA9876543210;
  localparam logic [63:0] INIT_C = 64'hF096A5B4C3B2E187;

  localparam logic [63:0] KS_C1 = 64'hA5A5A5A5A5A5A5A5;
  localparam logic [63:0] KS_C2 = 64'h0123456789ABCDEF;

  localparam int unsigned STD_PASSES = 3;
  localparam int unsigned MAX_PASSES = 8;
  localparam int unsigned GEN_ROUNDS = 5;

  // seed block for s-box generation, first byte in the low bits
  localparam logic [7:0][63:0] SEED_BLK = {
    64'h6D6168694220696C,
    64'h4520646E61206E6F,
    64'h737265646E412073,
    64'h736F52207962202C,
    64'h6E6F6974636E7546,
    64'h2068736148207765,
    64'h4E20747361462041,
    64'h202D207265676954
  };

endpackage

// File: rtl/core/tiger_hash_engine.sv
// tiger-192 hash engine: message packing, padding, compression and s-box memories
// depends on thash_pkg
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: word[63:0] count[67:64], tlast
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: digest word, tuser: index, tlast
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_data_i: num_passes
//
// no word is taken while a block is compressed; each round steps through the states
// CS0 to CS3 on the two s-box memories, and the key schedule runs between passes
// after reset each s-box entry is filled with its table index in every byte and the
// tables are then generated in place, during which no word is accepted
// a last word adds padding pushes and one or two more compressions; the digest leaves
// through output registers; a stalled output holds the next digest load in ST_DONE
module tiger_hash_engine
  import thash_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // message_word[63:0], byte_count[67:64], zero fill
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // digest_word[63:0]
  output logic [1:0]  m_axis_tuser,   // digest_index[1:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);

  localparam logic [4:0] ST_CLR    = 5'd0;
  localparam logic [4:0] ST_GSTEP  = 5'd1;
  localparam logic [4:0] ST_GLOAD  = 5'd2;
  localparam logic [4:0] ST_GLOADW = 5'd3;
  localparam logic [4:0] ST_GRD    = 5'd4;
  localparam logic [4:0] ST_GSW    = 5'd5;
  localparam logic [4:0] ST_GWB    = 5'd6;
  localparam logic [4:0] ST_IDLE   = 5'd7;
  localparam logic [4:0] ST_PAD1   = 5'd8;
  localparam logic [4:0] ST_PADZ   = 5'd9;
  localparam logic [4:0] ST_DONE   = 5'd10;
  localparam logic [4:0] ST_CSTART = 5'd11;
  localparam logic [4:0] ST_CS0    = 5'd12;
  localparam logic [4:0] ST_CS1    = 5'd13;
  localparam logic [4:0] ST_CS2    = 5'd14;
  localparam logic [4:0] ST_CS3    = 5'd15;
  localparam logic [4:0] ST_CKS    = 5'd16;
  localparam logic [4:0] ST_CFEED  = 5'd17;

  // s-box memories: mem0 holds tables 0 and 1, mem1 tables 2 and 3
  logic [63:0] mem0 [512];
  logic [63:0] mem1 [512];
  logic [8:0]  ra0a, ra0b, ra1a, ra1b, waddr;
  logic        we0, we1;
  logic [63:0] wdata;
  logic [63:0] rd0a_q, rd0b_q, rd1a_q, rd1b_q;

  logic [4:0]  state_q, ret_q;
  logic        gen_q;
  logic [3:0]  passes_cfg_q;
  logic [8:0]  clr_q;
  logic [2:0]  gr_q;
  logic [7:0]  gi_q;
  logic [1:0]  tb_q;
  logic [1:0]  sel_q;
  logic [2:0]  col_q;
  logic [7:0]  other_q;
  logic [63:0] hold_q;

  logic [63:0] ch_a_q, ch_b_q, ch_c_q;
  logic [63:0] x_q, y_q, z_q, v_q, acc_a_q;
  logic [63:0] bw_q [8];
  logic [3:0]  pass_q;
  logic [2:0]  rnd_q;
  logic [3:0]  ks_q;

  logic [2:0]  wib_q;
  logic [63:0] msg_bytes_q;
  logic [63:0] partial_q;
  logic [2:0]  pb_q;

  logic [63:0] dig_q [3];
  logic        out_valid_q;
  logic [1:0]  out_idx_q;

  // push path
  logic        push_en;
  logic [63:0] push_data;
  logic [3:0]  push_cnt;
  logic [63:0] push_mask;
  logic [127:0] push_comb;
  logic [3:0]  push_tot;
  logic        push_full;
  logic        blk_done;
  logic [3:0]  in_cnt;
  logic        in_fire;

  logic [63:0] v_c, acc_b, ymul, gen_rd, gen_ch, sw_word;
  logic [7:0]  gx, gy;
  logic [3:0]  passes_eff;
  logic [1:0]  sel_n;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign in_cnt        = (s_axis_tdata[67:64] > 4'd8) ? 4'd8 : s_axis_tdata[67:64];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = dig_q[out_idx_q];
  assign m_axis_tuser  = out_idx_q;
  assign m_axis_tlast  = (out_idx_q == 2'd2);

  always_comb begin
    if (gen_q) begin
      passes_eff = 4'(STD_PASSES);
    end else if (passes_cfg_q < 4'(STD_PASSES)) begin
      passes_eff = 4'(STD_PASSES);
    end else if (passes_cfg_q > 4'(MAX_PASSES)) begin
      passes_eff = 4'(MAX_PASSES);
    end else begin
      passes_eff = passes_cfg_q;
    end
  end

  always_comb begin
    push_en   = 1'b0;
    push_data = '0;
    push_cnt  = '0;
    case (state_q)
      ST_IDLE: begin
        push_en   = in_fire;
        push_data = s_axis_tdata[63:0];
        push_cnt  = in_cnt;
      end
      ST_PAD1: begin
        push_en   = 1'b1;
        push_data = 64'h1;
        push_cnt  = 4'd1;
      end
      ST_PADZ: begin
        push_en = 1'b1;
        if (pb_q != 3'd0) begin
          push_cnt = 4'd8 - {1'b0, pb_q};
        end else if (wib_q != 3'd7) begin
          push_cnt = 4'd8;
        end else begin
          push_data = {msg_bytes_q[60:0], 3'b000};
          push_cnt  = 4'd8;
        end
      end
      default: push_en = 1'b0;
    endcase
    push_mask = push_cnt[3] ? '1 : ((64'h1 << {push_cnt[2:0], 3'b000}) - 64'h1);
    push_comb = {64'h0, partial_q} | ({64'h0, push_data & push_mask} << {pb_q, 3'b000});
    push_tot  = {1'b0, pb_q} + push_cnt;
    push_full = push_tot[3];
    blk_done  = push_full && (wib_q == 3'd7);
  end

  // round datapath
  assign v_c   = z_q ^ bw_q[rnd_q];
  assign acc_b = rd0a_q ^ rd0b_q ^ rd1a_q ^ rd1b_q;
  always_comb begin
    if (pass_q == 4'd0) begin
      ymul = (y_q << 2) + y_q;
    end else if (pass_q == 4'd1) begin
      ymul = (y_q << 3) - y_q;
    end else begin
      ymul = (y_q << 3) + y_q;
    end
  end

  // generation datapath
  assign gen_rd = tb_q[1] ? rd1a_q : rd0a_q;
  always_comb begin
    case (sel_q)
      2'd0:    gen_ch = ch_a_q;
      2'd1:    gen_ch = ch_b_q;
      default: gen_ch = ch_c_q;
    endcase
    gx      = 8'(hold_q >> {col_q, 3'b000});
    gy      = (other_q == gi_q) ? gx : 8'(gen_rd >> {col_q, 3'b000});
    sw_word = (gen_rd & ~(64'hFF << {col_q, 3'b000})) | ({56'h0, gx} << {col_q, 3'b000});
    sel_n   = (sel_q == 2'd2) ? 2'd0 : sel_q + 2'd1;
  end

  // memory addressing
  always_comb begin
    ra0a  = '0;
    ra0b  = '0;
    ra1a  = '0;
    ra1b  = '0;
    we0   = 1'b0;
    we1   = 1'b0;
    waddr = '0;
    wdata = '0;
    case (state_q)
      ST_CLR: begin
        we0   = 1'b1;
        we1   = 1'b1;
        waddr = clr_q;
        wdata = {8{clr_q[7:0]}};
      end
      ST_GLOAD: begin
        ra0a = {tb_q[0], gi_q};
        ra1a = {tb_q[0], gi_q};
      end
      ST_GRD: begin
        ra0a = {tb_q[0], 8'(gen_ch >> {col_q, 3'b000})};
        ra1a = {tb_q[0], 8'(gen_ch >> {col_q, 3'b000})};
      end
      ST_GSW: begin
        we0   = !tb_q[1] && (other_q != gi_q);
        we1   = tb_q[1] && (other_q != gi_q);
        waddr = {tb_q[0], other_q};
        wdata = sw_word;
      end
      ST_GWB: begin
        we0   = !tb_q[1];
        we1   = tb_q[1];
        waddr = {tb_q[0], gi_q};
        wdata = hold_q;
      end
      ST_CS0: begin
        ra0a = {1'b0, v_c[7:0]};
        ra0b = {1'b1, v_c[23:16]};
        ra1a = {1'b0, v_c[39:32]};
        ra1b = {1'b1, v_c[55:48]};
      end
      ST_CS1: begin
        ra1a = {1'b1, v_q[15:8]};
        ra1b = {1'b0, v_q[31:24]};
        ra0a = {1'b1, v_q[47:40]};
        ra0b = {1'b0, v_q[63:56]};
      end
      default: we0 = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we0) begin
      mem0[waddr] <= wdata;
    end
    if (we1) begin
      mem1[waddr] <= wdata;
    end
    rd0a_q <= mem0[ra0a];
    rd0b_q <= mem0[ra0b];
    rd1a_q <= mem1[ra1a];
    rd1b_q <= mem1[ra1b];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_GLOADW: hold_q <= gen_rd;
      ST_GRD:    other_q <= 8'(gen_ch >> {col_q, 3'b000});
      ST_GSW:    hold_q <= (hold_q & ~(64'hFF << {col_q, 3'b000}))
                           | ({56'h0, gy} << {col_q, 3'b000});
      ST_CSTART: begin
        x_q <= ch_a_q;
        y_q <= ch_b_q;
        z_q <= ch_c_q;
        if (gen_q) begin
          for (int k = 0; k < 8; k++) begin
            bw_q[k] <= SEED_BLK[k];
          end
        end
      end
      ST_CS0: begin
        v_q <= v_c;
        z_q <= v_c;
      end
      ST_CS1: acc_a_q <= acc_b;
      ST_CS2: begin
        x_q <= x_q - acc_a_q;
        y_q <= y_q + acc_b;
      end
      ST_CS3: begin
        x_q <= ymul;
        y_q <= z_q;
        z_q <= x_q;
      end
      ST_CKS: begin
        case (ks_q)
          4'd0:  bw_q[0] <= bw_q[0] - (bw_q[7] ^ KS_C1);
          4'd1:  bw_q[1] <= bw_q[1] ^ bw_q[0];
          4'd2:  bw_q[2] <= bw_q[2] + bw_q[1];
          4'd3:  bw_q[3] <= bw_q[3] - (bw_q[2] ^ ((~bw_q[1]) << 19));
          4'd4:  bw_q[4] <= bw_q[4] ^ bw_q[3];
          4'd5:  bw_q[5] <= bw_q[5] + bw_q[4];
          4'd6:  bw_q[6] <= bw_q[6] - (bw_q[5] ^ ((~bw_q[4]) >> 23));
          4'd7:  bw_q[7] <= bw_q[7] ^ bw_q[6];
          4'd8:  bw_q[0] <= bw_q[0] + bw_q[7];
          4'd9:  bw_q[1] <= bw_q[1] - (bw_q[0] ^ ((~bw_q[7]) << 19));
          4'd10: bw_q[2] <= bw_q[2] ^ bw_q[1];
          4'd11: bw_q[3] <= bw_q[3] + bw_q[2];
          4'd12: bw_q[4] <= bw_q[4] - (bw_q[3] ^ ((~bw_q[2]) >> 23));
          4'd13: bw_q[5] <= bw_q[5] ^ bw_q[4];
          4'd14: bw_q[6] <= bw_q[6] + bw_q[5];
          default: bw_q[7] <= bw_q[7] - (bw_q[6] ^ KS_C2);
        endcase
      end
      default: begin
        if (push_en && push_full) begin
          bw_q[wib_q] <= push_comb[63:0];
        end
      end
    endcase
    if (state_q == ST_DONE && !out_valid_q) begin
      dig_q[0] <= ch_a_q;
      dig_q[1] <= ch_b_q;
      dig_q[2] <= ch_c_q;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      ret_q        <= ST_IDLE;
      gen_q        <= 1'b1;
      passes_cfg_q <= 4'(STD_PASSES);
      clr_q        <= '0;
      gr_q         <= '0;
      gi_q         <= '0;
      tb_q         <= '0;
      sel_q        <= 2'd2;
      col_q        <= '0;
      ch_a_q       <= INIT_A;
      ch_b_q       <= INIT_B;
      ch_c_q       <= INIT_C;
      pass_q       <= '0;
      rnd_q        <= '0;
      ks_q         <= '0;
      wib_q        <= '0;
      msg_bytes_q  <= '0;
      partial_q    <= '0;
      pb_q         <= '0;
      out_valid_q  <= 1'b0;
      out_idx_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        passes_cfg_q <= cfg_data_i;
      end
      if (out_valid_q && m_axis_tready) begin
        if (out_idx_q == 2'd2) begin
          out_valid_q <= 1'b0;
          out_idx_q   <= '0;
        end else begin
          out_idx_q <= out_idx_q + 2'd1;
        end
      end
      if (push_en) begin
        if (push_full) begin
          partial_q <= push_comb[127:64];
          wib_q     <= wib_q + 3'd1;
        end else begin
          partial_q <= push_comb[63:0];
        end
        pb_q <= push_tot[2:0];
      end
      case (state_q)
        ST_CLR: begin
          clr_q <= clr_q + 9'd1;
          if (clr_q == 9'd511) begin
            state_q <= ST_GSTEP;
          end
        end
        ST_GSTEP: begin
          sel_q <= sel_n;
          if (sel_q == 2'd2) begin
            ret_q   <= ST_GLOAD;
            state_q <= ST_CSTART;
          end else begin
            state_q <= ST_GLOAD;
          end
        end
        ST_GLOAD:  state_q <= ST_GLOADW;
        ST_GLOADW: begin
          col_q   <= '0;
          state_q <= ST_GRD;
        end
        ST_GRD: state_q <= ST_GSW;
        ST_GSW: begin
          col_q <= col_q + 3'd1;
          state_q <= (col_q == 3'd7) ? ST_GWB : ST_GRD;
        end
        ST_GWB: begin
          tb_q    <= tb_q + 2'd1;
          state_q <= ST_GSTEP;
          if (tb_q == 2'd3) begin
            gi_q <= gi_q + 8'd1;
            if (gi_q == 8'd255) begin
              gr_q <= gr_q + 3'd1;
              if (gr_q == 3'(GEN_ROUNDS - 1)) begin
                gen_q   <= 1'b0;
                ch_a_q  <= INIT_A;
                ch_b_q  <= INIT_B;
                ch_c_q  <= INIT_C;
                state_q <= ST_IDLE;
              end
            end
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            msg_bytes_q <= msg_bytes_q + 64'(in_cnt);
            if (blk_done) begin
              ret_q   <= s_axis_tlast ? ST_PAD1 : ST_IDLE;
              state_q <= ST_CSTART;
            end else if (s_axis_tlast) begin
              state_q <= ST_PAD1;
            end
          end
        end
        ST_PAD1: begin
          if (blk_done) begin
            ret_q   <= ST_PADZ;
            state_q <= ST_CSTART;
          end else begin
            state_q <= ST_PADZ;
          end
        end
        ST_PADZ: begin
          if (blk_done) begin
            ret_q   <= (pb_q == 3'd0) ? ST_DONE : ST_PADZ;
            state_q <= ST_CSTART;
          end
        end
        ST_DONE: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= '0;
            ch_a_q      <= INIT_A;
            ch_b_q      <= INIT_B;
            ch_c_q      <= INIT_C;
            msg_bytes_q <= '0;
            wib_q       <= '0;
            partial_q   <= '0;
            pb_q        <= '0;
            state_q     <= ST_IDLE;
          end
        end
        ST_CSTART: begin
          pass_q  <= '0;
          rnd_q   <= '0;
          state_q <= ST_CS0;
        end
        ST_CS0: state_q <= ST_CS1;
        ST_CS1: state_q <= ST_CS2;
        ST_CS2: state_q <= ST_CS3;
        ST_CS3: begin
          rnd_q <= rnd_q + 3'd1;
          if (rnd_q != 3'd7) begin
            state_q <= ST_CS0;
          end else if (pass_q + 4'd1 == passes_eff) begin
            state_q <= ST_CFEED;
          end else begin
            pass_q  <= pass_q + 4'd1;
            ks_q    <= '0;
            state_q <= ST_CKS;
          end
        end
        ST_CKS: begin
          ks_q <= ks_q + 4'd1;
          if (ks_q == 4'd15) begin
            state_q <= ST_CS0;
          end
        end
        ST_CFEED: begin
          ch_a_q  <= x_q ^ ch_a_q;
          ch_b_q  <= y_q - ch_b_q;
          ch_c_q  <= z_q + ch_c_q;
          state_q <= ret_q;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // no digest while the s-boxes are being built
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_q |-> !m_axis_tvalid)
    else $error("digest output during s-box generation");

  // a last word always leads into padding, never straight back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast) |=> !s_axis_tready)
    else $error("last word did not start padding");

  // a digest is loaded only into a free output and starts at index a
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_valid_q) |=> (out_valid_q && out_idx_q == 2'd0))
    else $error("digest load lost or misaligned");

endmodule

// File: sim/tiger_hash_checker.sv
`timescale 1ns / 1ps
// checker for the tiger hash engine: watches the input, output and config channels,
// predicts the digest of every message and compares it with the output stream
// depends on thash_pkg
module tiger_hash_checker
  import thash_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [71:0] s_data_i,
  input  logic        s_last_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [63:0] m_data_i,
  input  logic [1:0]  m_user_i,
  input  logic        m_last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [3:0]  cfg_data_i,
  output int          fail_count_o,
  output int          digests_pending_o
);

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  index;
    logic        last;
  } digest_t;

  logic [63:0]      sbox [1024];
  digest_t          digest_q[$];
  logic [63:0]      hash_a, hash_b, hash_c;
  logic [7:0][63:0] blk_words;
  int               blk_fill;
  logic [63:0]      msg_len;
  logic [63:0]      pend_word;
  int               pend_bytes;
  logic [3:0]       pass_reg;

  assign digests_pending_o = digest_q.size();

  function automatic logic [63:0] sbox_rd(int t, logic [63:0] v);
    return sbox[{t[1:0], v[7:0]}];
  endfunction

  task automatic round_mix(inout logic [63:0] a, inout logic [63:0] b,
                           inout logic [63:0] c, input logic [63:0] x,
                           input logic [63:0] mul);
    logic [63:0] v;
    v = c ^ x;
    c = v;
    a = a - (sbox_rd(0, v) ^ sbox_rd(1, v >> 16) ^ sbox_rd(2, v >> 32) ^
             sbox_rd(3, v >> 48));
    b = b + (sbox_rd(3, v >> 8) ^ sbox_rd(2, v >> 24) ^ sbox_rd(1, v >> 40) ^
             sbox_rd(0, v >> 56));
    b = b * mul;
  endtask

  task automatic compress_state(inout logic [63:0] s0, inout logic [63:0] s1,
                                inout logic [63:0] s2, input logic [7:0][63:0] blk,
                                input int passes);
    logic [7:0][63:0] w;
    logic [63:0] a, b, c, t, mul;
    w = blk;
    a = s0;
    b = s1;
    c = s2;
    for (int j = 0; j < passes; j++) begin
      if (j != 0) begin
        w[0] = w[0] - (w[7] ^ KS_C1);
        w[1] = w[1] ^ w[0];
        w[2] = w[2] + w[1];
        w[3] = w[3] - (w[2] ^ ((~w[1]) << 19));
        w[4] = w[4] ^ w[3];
        w[5] = w[5] + w[4];
        w[6] = w[6] - (w[5] ^ ((~w[4]) >> 23));
        w[7] = w[7] ^ w[6];
        w[0] = w[0] + w[7];
        w[1] = w[1] - (w[0] ^ ((~w[7]) << 19));
        w[2] = w[2] ^ w[1];
        w[3] = w[3] + w[2];
        w[4] = w[4] - (w[3] ^ ((~w[2]) >> 23));
        w[5] = w[5] ^ w[4];
        w[6] = w[6] + w[5];
        w[7] = w[7] - (w[6] ^ KS_C2);
      end
      mul = (j == 0) ? 64'd5 : ((j == 1) ? 64'd7 : 64'd9);
      round_mix(a, b, c, w[0], mul);
      round_mix(b, c, a, w[1], mul);
      round_mix(c, a, b, w[2], mul);
      round_mix(a, b, c, w[3], mul);
      round_mix(b, c, a, w[4], mul);
      round_mix(c, a, b, w[5], mul);
      round_mix(a, b, c, w[6], mul);
      round_mix(b, c, a, w[7], mul);
      t = a;
      a = c;
      c = b;
      b = t;
    end
    s0 = a ^ s0;
    s1 = b - s1;
    s2 = c + s2;
  endtask

  // s-box tables from the seed text
  initial begin
    logic [63:0] g0, g1, g2, pick;
    int sel, other;
    logic [7:0] x, y;
    g0 = INIT_A;
    g1 = INIT_B;
    g2 = INIT_C;
    sel = 2;
    for (int i = 0; i < 1024; i++) sbox[i] = 64'(i & 255) * 64'h0101010101010101;
    for (int r = 0; r < GEN_ROUNDS; r++) begin
      for (int i = 0; i < 256; i++) begin
        for (int base = 0; base < 1024; base += 256) begin
          sel++;
          if (sel == 3) begin
            sel = 0;
            compress_state(g0, g1, g2, SEED_BLK, STD_PASSES);
          end
          pick = (sel == 0) ? g0 : ((sel == 1) ? g1 : g2);
          for (int col = 0; col < 8; col++) begin
            other = base + int'(pick[8*col +: 8]);
            x = sbox[base + i][8*col +: 8];
            y = sbox[other][8*col +: 8];
            sbox[base + i][8*col +: 8] = y;
            sbox[other][8*col +: 8] = x;
          end
        end
      end
    end
  end

  task automatic restart_message();
    hash_a = INIT_A;
    hash_b = INIT_B;
    hash_c = INIT_C;
    blk_fill = 0;
    msg_len = '0;
    pend_word = '0;
    pend_bytes = 0;
  endtask

  task automatic append_byte(logic [7:0] v);
    int p;
    pend_word[8*pend_bytes +: 8] = v;
    pend_bytes++;
    if (pend_bytes == 8) begin
      blk_words[blk_fill] = pend_word;
      pend_word = '0;
      pend_bytes = 0;
      blk_fill++;
      if (blk_fill == 8) begin
        p = (pass_reg < 3) ? 3 : ((pass_reg > 8) ? 8 : int'(pass_reg));
        blk_fill = 0;
        compress_state(hash_a, hash_b, hash_c, blk_words, p);
      end
    end
  endtask

  task automatic absorb_word(logic [63:0] word, logic [3:0] cnt, logic last);
    int n;
    logic [63:0] bits;
    n = (cnt > 8) ? 8 : int'(cnt);
    for (int i = 0; i < n; i++) append_byte(word[8*i +: 8]);
    msg_len = msg_len + 64'(n);
    if (last) begin
      bits = msg_len << 3;
      append_byte(8'h01);
      while (blk_fill * 8 + pend_bytes != 56) append_byte(8'h00);
      for (int i = 0; i < 8; i++) append_byte(bits[8*i +: 8]);
      digest_q.push_back('{hash_a, 2'd0, 1'b0});
      digest_q.push_back('{hash_b, 2'd1, 1'b0});
      digest_q.push_back('{hash_c, 2'd2, 1'b1});
      restart_message();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_t exp_d;
    if (!rst_ni) begin
      pass_reg = 4'd3;
      fail_count_o = 0;
      restart_message();
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (digest_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected digest transaction: word %h index %0d last %0b",
                     m_data_i, m_user_i, m_last_i);
        end else begin
          exp_d = digest_q.pop_front();
          if (exp_d.word !== m_data_i || exp_d.index !== m_user_i ||
              exp_d.last !== m_last_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("digest mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                       exp_d.word, exp_d.index, exp_d.last, m_data_i, m_user_i, m_last_i);
          end
        end
      end
      if (s_valid_i && s_ready_i) absorb_word(s_data_i[63:0], s_data_i[67:64], s_last_i);
      if (cfg_valid_i && cfg_ready_i) pass_reg = cfg_data_i;
    end
  end

endmodule

// File: sim/tb_tiger_hash_engine.sv
`timescale 1ns / 1ps
// testbench top for the tiger hash engine: clock, reset, message stimulus with random
// gaps and output stalls, pass count phases; depends on tiger_hash_engine
// and tiger_hash_checker
module tb_tiger_hash_engine;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i;
  int          fail_count;
  int          digests_pending;
  logic        quiet_mode;
  logic        hold_req;
  logic        hold_done;

  tiger_hash_engine u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  tiger_hash_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_valid_i        (s_axis_tvalid),
    .s_ready_i        (s_axis_tready),
    .s_data_i         (s_axis_tdata),
    .s_last_i         (s_axis_tlast),
    .m_valid_i        (m_axis_tvalid),
    .m_ready_i        (m_axis_tready),
    .m_data_i         (m_axis_tdata),
    .m_user_i         (m_axis_tuser),
    .m_last_i         (m_axis_tlast),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .digests_pending_o(digests_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("[tiger_hash_engine] ERROR");
    $finish;
  end

  // digest receiver with random stalls and one long hold-off
  initial begin
    int idle_left;
    idle_left = 0;
    hold_done = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready = 1'b0;
        repeat (6000) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (quiet_mode) begin
        m_axis_tready = 1'b1;
      end else if (idle_left > 0) begin
        m_axis_tready = 1'b0;
        idle_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        idle_left = $urandom_range(0, 7);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic send_word(logic [63:0] word, logic [3:0] cnt, logic last);
    if (!quiet_mode && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'b0, cnt, word};
    s_axis_tlast  = last;
    // ready is stable between rising edges, so it is checked mid-cycle
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain_digests();
    while (digests_pending != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  task automatic write_passes(logic [3:0] v);
    drain_digests();
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_message(int n_words);
    logic [3:0] cnt;
    for (int i = 0; i < n_words; i++) begin
      cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
      send_word(rand_word(), cnt, 1'b0);
    end
    cnt = ($urandom_range(0, 2) == 0) ? 4'd8 : 4'($urandom_range(0, 15));
    send_word(rand_word(), cnt, 1'b1);
  endtask

  initial begin
    logic [3:0] phase_passes [6];
    phase_passes = '{4'd8, 4'd0, 4'd15, 4'd5, 4'd3, 4'($urandom_range(0, 15))};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 4'd3;
    quiet_mode    = 1'b0;
    hold_req      = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed messages at the standard pass count
    send_word('0, 4'd0, 1'b1);
    send_word('1, 4'd8, 1'b1);
    send_word(64'h0000_0000_0000_0061, 4'd1, 1'b1);
    send_word(64'h0123456789ABCDEF, 4'd15, 1'b1);
    send_word(64'hFFEEDDCCBBAA9988, 4'd3, 1'b0);
    send_word(64'h7766554433221100, 4'd9, 1'b0);
    send_word(64'h5A5A5A5A5A5A5A5A, 4'd7, 1'b1);
    for (int i = 0; i < 7; i++) send_word({$urandom, $urandom}, 4'd8, 1'b0);
    send_word('1, 4'd8, 1'b1);
    for (int i = 0; i < 6; i++) send_word({$urandom, $urandom}, 4'd8, 1'b0);
    send_word(64'hA5A5A5A5A5A5A5A5, 4'd7, 1'b1);

    foreach (phase_passes[p]) begin
      write_passes(phase_passes[p]);
      if (p == 4) quiet_mode = 1'b1;
      if (p == 1) hold_req = 1'b1;
      for (int m = 0; m < 7; m++) begin
        if (p == 1) send_message($urandom_range(0, 2));
        else if (p == 3 && m == 0) send_message(17);
        else send_message($urandom_range(0, 9));
      end
    end
    drain_digests();
    if (fail_count == 0) begin
      $display("[tiger_hash_engine] OK");
    end else begin
      $display("[tiger_hash_engine] ERROR");
    end
    $finish;
  end

endmodule
